[rtl/lru_way_replacement_unit_assert.svh]
// ---------------------------------------------------------------------------
// LRU way replacement unit: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LRU_WAY_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_WAY_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lru_pkg.sv]
// ---------------------------------------------------------------------------
// lru_pkg
// Shared types and constants of the LRU way replacement unit.
// ---------------------------------------------------------------------------
package lru_pkg;

    // Ways of one set and derived widths
    localparam int WAYS    = 8;
    localparam int IDX_W   = $clog2(WAYS);
    localparam int WAY_W   = 3;
    localparam int COUNT_W = 4;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    typedef logic [WAY_W-1:0]   t_way;
    typedef logic [COUNT_W-1:0] t_count;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_HIT    = 2'd0,
        REQ_FILL   = 2'd1,
        REQ_VICTIM = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_HELD = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;   // capture the incoming item
        logic exec;       // apply the captured item and load the result
    } t_cmd;

endpackage

[rtl/lru_ctrl.sv]
// ---------------------------------------------------------------------------
// lru_ctrl
// Sequencer: takes one item, runs it through the datapath, owns output valid.
// ---------------------------------------------------------------------------
module lru_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output lru_pkg::t_cmd o_cmd
);
    import lru_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Result slot is free when empty or being taken this cycle
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_cmd.load_req = i_s_tvalid && (r_state == S_IDLE);
    assign o_cmd.exec     = (r_state == S_EXEC) && w_out_free;

    // Next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/lru_dp.sv]
// ---------------------------------------------------------------------------
// lru_dp
// Recency list, held count, request capture and result registers.
// ---------------------------------------------------------------------------
module lru_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lru_pkg::t_cmd    i_cmd,
    input  lru_pkg::t_req    i_req_type,
    input  lru_pkg::t_way    i_way,
    output lru_pkg::t_way    o_victim_way,
    output lru_pkg::t_status o_status,
    output lru_pkg::t_count  o_occupancy
);
    import lru_pkg::*;

    // Captured request
    t_req    r_req;
    t_way    r_way;

    // List state, position 0 is MRU
    t_way    r_order [WAYS];
    t_way    n_order [WAYS];
    t_count  r_count;
    t_count  n_count;

    // Result registers
    t_way    r_victim;
    t_way    n_victim;
    t_status r_status;
    t_status n_status;

    logic [WAYS-1:0]  w_match;
    logic             w_found;
    t_count           w_pos;
    t_count           w_upto;
    logic             w_shift;
    logic             w_way_ok;
    t_count           w_last;
    t_way             w_shifted [WAYS];

    // Compare every held entry against the request way
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_match[i] = (COUNT_W'(i) < r_count) && (r_order[i] == r_way);
        end
    end

    // Position of the matching entry, first one wins
    always_comb begin
        w_pos = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_pos = COUNT_W'(i);
            end
        end
    end

    assign w_found  = |w_match;
    assign w_way_ok = ({1'b0, r_way} < (WAY_W+1)'(WAYS));
    assign w_last   = r_count - COUNT_W'(1);

    // Move entries below w_upto down one slot, request way to the front
    always_comb begin
        w_shifted[0] = r_way;
        for (int i = 1; i < WAYS; i++) begin
            w_shifted[i] = (COUNT_W'(i) <= w_upto) ? r_order[i-1] : r_order[i];
        end
    end

    // Request decode and update
    always_comb begin
        n_count  = r_count;
        n_victim = '0;
        n_status = ST_OK;
        w_shift  = 1'b0;
        w_upto   = w_pos;
        unique case (r_req)
            REQ_HIT: begin
                if (w_found) begin
                    w_shift = 1'b1;
                end else begin
                    n_status = ST_NOT_HELD;
                end
            end
            REQ_FILL: begin
                if (!w_way_ok) begin
                    n_status = ST_NOT_HELD;
                end else if (w_found) begin
                    w_shift = 1'b1;
                end else if (r_count >= COUNT_W'(WAYS)) begin
                    n_status = ST_FULL;
                end else begin
                    w_shift = 1'b1;
                    w_upto  = r_count;
                    n_count = r_count + COUNT_W'(1);
                end
            end
            REQ_VICTIM: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_victim = r_order[w_last[IDX_W-1:0]];
                    n_count  = w_last;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Next list contents
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            n_order[i] = w_shift ? w_shifted[i] : r_order[i];
        end
    end

    // Held count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_way <= i_way;
        end
        if (i_cmd.exec) begin
            r_order  <= n_order;
            r_victim <= n_victim;
            r_status <= n_status;
        end
    end

    assign o_victim_way = r_victim;
    assign o_status     = r_status;
    assign o_occupancy  = r_count;

endmodule

[rtl/lru_way_replacement_unit.sv]
// ---------------------------------------------------------------------------
// lru_way_replacement_unit
// True LRU replacement policy for the ways of one cache set.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel carries one request item: tuser holds the request kind
//   (hit update, fill after miss, take victim), tdata the way index.
//   Master channel returns one result item per request: the victim way,
//   the held count after the request (tdata) and a status code (tuser).
//   Each item is captured while the sequencer is idle; the recency list
//   is then compared, shifted and written in the update step, which also
//   registers the result. No new item is taken during the update step.
//   The result register lets the next item be taken while a result waits;
//   if the receiver stalls, that item parks in the update step until the
//   result register is free, and the slave side then stops accepting.
//   Reset empties the list (held count zero) and drops any pending result;
//   list entries are not cleared, only the held ones are ever looked at.
//   A failed request leaves the list untouched and reports its status.
// ---------------------------------------------------------------------------
module lru_way_replacement_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [2:0] way, [7:3] zero
    input  logic [1:0] i_s_tuser,   // [1:0] req_type
    // Result channel
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [2:0] victim_way, [6:3] occupancy, [7] zero
    output logic [1:0] o_m_tuser    // [1:0] status
);
    import lru_pkg::*;

    t_cmd    w_cmd;
    t_way    w_victim;
    t_status w_status;
    t_count  w_occ;

    // Sequencer
    lru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // Recency list datapath
    lru_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_type   (t_req'(i_s_tuser)),
        .i_way        (i_s_tdata[WAY_W-1:0]),
        .o_victim_way (w_victim),
        .o_status     (w_status),
        .o_occupancy  (w_occ)
    );

    // Pack result item
    assign o_m_tdata = {1'b0, w_occ, w_victim};
    assign o_m_tuser = w_status;

    `include "lru_way_replacement_unit_assert.svh"

    // Accepted item blocks the slave side during its update step
    `LRU_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready,
        !o_s_tready, "accepted item did not block intake")
    // Held count never above the set size
    `LRU_ASSERT_NOW(a_occ_bound, o_m_tvalid,
        o_m_tdata[6:3] <= COUNT_W'(WAYS), "occupancy above way count")
    // Failed request reports no victim
    `LRU_ASSERT_NOW(a_no_victim_on_err, o_m_tvalid && (o_m_tuser != ST_OK),
        o_m_tdata[2:0] == '0, "victim on failed request")

endmodule

[bench/tb_lru_way_replacement_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lru_way_replacement_unit
// Self-checking bench for the true LRU way replacement unit. A short table
// of directed requests walks the list from empty to full and back. A
// random mix of hit, fill and victim requests follows, in fill-heavy,
// victim-heavy and balanced phases. Each result item is compared with an
// in-bench model of the recency list, with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_lru_way_replacement_unit;
    import lru_pkg::*;

    localparam int RAND_ITEMS = 400;
    localparam int QUIET_FROM = 320;     // no idling from this random item on
    localparam int PAUSE_AT   = 200;     // sender drains the pipe here
    localparam int CYCLE_CAP  = 200000;

    // Expected result of one request
    typedef struct packed {
        t_way    victim;
        t_status status;
        t_count  occ;
    } t_lru_res;

    // Directed row: request plus an optional hand-written result
    typedef struct packed {
        t_req    req;
        t_way    way;
        logic    typed;
        t_way    victim;
        t_status status;
        t_count  occ;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        '{REQ_VICTIM, 3'd0, 1'b1, 3'd0, ST_EMPTY,    4'd0},  // victim from empty list
        '{REQ_HIT,    3'd7, 1'b1, 3'd0, ST_NOT_HELD, 4'd0},  // hit on way not held
        '{REQ_NONE,   3'd5, 1'b1, 3'd0, ST_OK,       4'd0},  // unused request kind
        '{REQ_FILL,   3'd0, 1'b1, 3'd0, ST_OK,       4'd1},
        '{REQ_FILL,   3'd7, 1'b1, 3'd0, ST_OK,       4'd2},
        '{REQ_FILL,   3'd0, 1'b0, 3'd0, ST_OK,       4'd0},  // fill of a held way
        '{REQ_HIT,    3'd7, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_FILL,   3'd1, 1'b1, 3'd0, ST_OK,       4'd3},
        '{REQ_FILL,   3'd2, 1'b1, 3'd0, ST_OK,       4'd4},
        '{REQ_FILL,   3'd3, 1'b1, 3'd0, ST_OK,       4'd5},
        '{REQ_FILL,   3'd4, 1'b1, 3'd0, ST_OK,       4'd6},
        '{REQ_FILL,   3'd5, 1'b1, 3'd0, ST_OK,       4'd7},
        '{REQ_FILL,   3'd6, 1'b1, 3'd0, ST_OK,       4'd8},
        '{REQ_FILL,   3'd3, 1'b0, 3'd0, ST_OK,       4'd0},  // held way moved, list full
        '{REQ_NONE,   3'd2, 1'b1, 3'd0, ST_OK,       4'd8},
        '{REQ_VICTIM, 3'd7, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_FILL,   3'd4, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd1, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd6, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd0, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd5, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd2, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd3, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd4, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd7, 1'b0, 3'd0, ST_OK,       4'd0},
        '{REQ_VICTIM, 3'd7, 1'b1, 3'd0, ST_EMPTY,    4'd0}   // drained list
    };

    // DUT ports
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'd0;   // [2:0] way, [7:3] zero
    logic [1:0] i_s_tuser  = 2'd0;   // [1:0] req_type
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [2:0] victim_way, [6:3] occupancy, [7] zero
    logic [1:0] o_m_tuser;           // [1:0] status

    // Model of the recency list, MRU at index 0
    t_way     lru_order [0:WAYS-1];
    t_count   lru_held = '0;

    t_lru_res lru_expect_q [$];      // results still owed by the DUT
    t_dir_row req_note_q [$];        // per sent item: hand-written result, if any
    t_lru_res pred_res;
    t_lru_res got_res;
    t_dir_row note;

    logic     idle_on  = 1'b1;
    int       rx_stall = 0;
    int       cycle_cnt = 0;
    int       errors = 0;

    lru_way_replacement_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shift entries [0, upto) back by one and put w at MRU
    function automatic void move_to_mru(int upto, t_way w);
        int i;
        for (i = upto; i > 0; i--)
            lru_order[i] = lru_order[i-1];
        lru_order[0] = w;
    endfunction

    // Apply one request to the list model and return its result
    function automatic t_lru_res apply_lru_req(t_req req, t_way w);
        t_lru_res r;
        int       pos;
        int       i;
        r   = '{victim: '0, status: ST_OK, occ: '0};
        pos = -1;
        for (i = 0; i < int'(lru_held); i++)
            if (pos < 0 && lru_order[i] == w)
                pos = i;
        case (req)
            REQ_HIT: begin
                if (pos < 0)
                    r.status = ST_NOT_HELD;
                else
                    move_to_mru(pos, w);
            end
            REQ_FILL: begin
                if (pos >= 0) begin
                    move_to_mru(pos, w);
                end else if (int'(lru_held) >= WAYS) begin
                    r.status = ST_FULL;
                end else begin
                    move_to_mru(int'(lru_held), w);
                    lru_held = lru_held + 1'b1;
                end
            end
            REQ_VICTIM: begin
                if (lru_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.victim = lru_order[lru_held-1];
                    lru_held = lru_held - 1'b1;
                end
            end
            default: ;   // unused kind leaves the list alone
        endcase
        r.occ = lru_held;
        return r;
    endfunction

    task automatic note_mismatch(string field, int exp_v, int act_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s expected %0d got %0d", $realtime, field, exp_v, act_v);
    endtask

    // Result side: random stall bursts
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall   <= rx_stall - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall   <= $urandom_range(0, 14);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog, prediction on accepted requests, check on accepted results
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("lru_way_replacement_unit: mismatch");
            $finish;
        end else if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pred_res = apply_lru_req(t_req'(i_s_tuser), t_way'(i_s_tdata[2:0]));
                note     = req_note_q.pop_front();
                if (note.typed)
                    pred_res = '{victim: note.victim, status: note.status, occ: note.occ};
                lru_expect_q.push_back(pred_res);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (lru_expect_q.size() == 0) begin
                    note_mismatch("unexpected item, status", -1, o_m_tuser);
                end else begin
                    got_res = lru_expect_q.pop_front();
                    if (o_m_tdata[2:0] != got_res.victim)
                        note_mismatch("victim_way", got_res.victim, o_m_tdata[2:0]);
                    if (o_m_tuser != got_res.status)
                        note_mismatch("status", got_res.status, o_m_tuser);
                    if (o_m_tdata[6:3] != got_res.occ)
                        note_mismatch("occupancy", got_res.occ, o_m_tdata[6:3]);
                end
            end
        end
    end

    // Request side
    initial begin : stim
        int       k;
        int       mode;
        int       pick;
        int       th_fill;
        int       th_hit;
        int       th_vic;
        int       gap;
        t_req     req;
        t_way     way;
        t_dir_row row;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS + RAND_ITEMS; k++) begin
            if (k < DIR_ROWS) begin
                row = dir_tab[k];
            end else begin
                // new traffic mix every 40 items
                if ((k - DIR_ROWS) % 40 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       begin th_fill = 50; th_hit = 85; th_vic = 97; end
                    1:       begin th_fill = 20; th_hit = 45; th_vic = 95; end
                    default: begin th_fill = 35; th_hit = 70; th_vic = 95; end
                endcase
                pick = $urandom_range(0, 99);
                if (pick < th_fill)
                    req = REQ_FILL;
                else if (pick < th_hit)
                    req = REQ_HIT;
                else if (pick < th_vic)
                    req = REQ_VICTIM;
                else
                    req = REQ_NONE;
                way = t_way'($urandom_range(0, 7));
                row = '{req: req, way: way, typed: 1'b0, victim: '0,
                        status: ST_OK, occ: '0};
                if (k - DIR_ROWS == QUIET_FROM)
                    idle_on <= 1'b0;
            end

            // hold off until the pipe has drained
            if (k == DIR_ROWS + PAUSE_AT) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (lru_expect_q.size() != 0)
                    @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_s_tvalid <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge i_clk);
            end

            req_note_q.push_back(row);
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {5'd0, row.way};
            i_s_tuser  <= row.req;
            do
                @(posedge i_clk);
            while (!o_s_tready);
        end
        i_s_tvalid <= 1'b0;

        while (lru_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0)
            $display("lru_way_replacement_unit: match");
        else
            $display("lru_way_replacement_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/lru_pkg.sv
rtl/lru_ctrl.sv
rtl/lru_dp.sv
rtl/lru_way_replacement_unit.sv
bench/tb_lru_way_replacement_unit.sv
